// ===== hdl/mstc_pkg.sv =====
// Shared constants, types and state encodings for the microstate template classifier.
package mstc_pkg;

  // Storage dimensions and field widths.
  localparam int MAX_TEMPLATES = 8;
  localparam int MAX_CHANNELS  = 64;
  localparam int SAMPLE_BITS   = 24;
  localparam int COEF_BITS     = 16;

  localparam int CH_AW   = $clog2(MAX_CHANNELS);
  localparam int TM_AW   = $clog2(MAX_TEMPLATES);
  localparam int TS_AW   = $clog2(MAX_TEMPLATES * MAX_CHANNELS);
  localparam int SUM_W   = SAMPLE_BITS + CH_AW;
  localparam int Y_W     = 32;
  localparam int PROD_W  = 2 * Y_W;
  localparam int ACC_W   = 68;
  localparam int ENG_W   = 67;
  localparam int DOT_W   = 54;
  localparam int MAG_W   = 52;
  localparam int REM_W   = 108;
  localparam int Q_W     = 32;
  localparam int CORR_W  = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_TEMPLATES = 2'd0;
  localparam logic [1:0] REG_CHANNELS  = 2'd1;
  localparam logic [1:0] REG_POLARITY  = 2'd2;
  localparam logic [1:0] REG_DEMEAN    = 2'd3;

  // Input function codes and the label of a zero-energy vector.
  localparam logic FUNC_TEMPLATE = 1'b0;
  localparam logic FUNC_SAMPLE   = 1'b1;
  localparam logic signed [3:0] LABEL_NONE = -4'sd1;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SUM,
    SEQ_ENERGY,
    SEQ_ECHECK,
    SEQ_DOT,
    SEQ_BEST,
    SEQ_CORR,
    SEQ_DONE
  } seq_e;

  // Pass currently streamed through the multiply-accumulate unit.
  typedef enum logic [1:0] {
    PASS_SUM,
    PASS_ENERGY,
    PASS_DOT
  } pass_e;

  // States of the correlation finishing unit.
  typedef enum logic [1:0] {
    CORR_IDLE,
    CORR_SQUARE,
    CORR_DIVIDE,
    CORR_ROOT
  } corr_e;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic              valid;
    logic              last;
    pass_e             pass;
    logic              clr_sum;
    logic              clr_acc;
    logic              first_tmpl;
    logic              demean;
    logic              inv;
    logic [TM_AW-1:0]  k;
    logic [CH_AW:0]    nc;
  } mac_ctl_t;

endpackage

// ===== hdl/microstate_template_classifier_unit.sv =====
// Top level of the microstate template classifier: configuration, sequencer and result register.
//
// Input channel: one transaction per template element (func 0) or channel sample (func 1).
// Template writes and samples of channels other than the last in use are stored and cause
// no result. The sample of the last channel in use completes a scalp vector;
// in_stall_o then stays high while the vector is classified, and one result transaction
// (label, corr) follows on the output channel.
// A completing sample, with C channels and T templates in use, runs the channel sum, the
// energy pass, the energy check, one dot product pass per template and the choice of the
// best template, then the correlation unit (52 square steps, 33 divide steps, 16 root steps,
// a done step) and the output load. A saturated correlation ends the root steps after one.
// A zero-energy vector skips the dot products and the correlation unit.
// All passes stream through one shared multiply-accumulate unit, one channel per cycle, reading the
// vector buffer and the template store through their single read ports.
// The result sits in an output register. If the receiver stalls, the block still accepts
// template writes and non-completing samples; a further completed vector waits for the
// output register to empty before its result is loaded.
// Reset returns the registers to four templates, 32 channels, polarity invariant and mean
// removal on, and empties the output register. Memories are not cleared: every template
// element and channel in use must be written before a vector is completed.
module microstate_template_classifier_unit import mstc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [6:0]                    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [2:0]                    template_index_i,
  input  logic [5:0]                    channel_index_i,
  input  logic signed [COEF_BITS-1:0]   template_value_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [3:0]             label_o,
  output logic [CORR_W-1:0]             corr_o
);

  seq_e                          state_q, state_d;
  logic [3:0]                    tiu_q, nt_eff;
  logic [6:0]                    ciu_q, nc_eff;
  logic                          pol_q, dm_q;
  logic [CH_AW:0]                c_q, c_d;
  logic [TM_AW-1:0]              k_q, k_d;
  logic                          v1_q, last1_q;
  logic                          issue, accept, start_vec;
  logic signed [3:0]             res_label_q, res_label_d;
  logic [CORR_W-1:0]             res_corr_q, res_corr_d;
  logic                          out_valid_q, load_out;
  logic signed [3:0]             label_q;
  logic [CORR_W-1:0]             corr_q;
  mac_ctl_t                      mac_ctl;
  logic                          mac_done, corr_start, corr_done;
  logic [ENG_W-1:0]              energy;
  logic signed [DOT_W-1:0]       best_key;
  logic [TM_AW-1:0]              best_k;
  logic [CORR_W-1:0]             corr_val;
  logic signed [SAMPLE_BITS-1:0] x_rd;
  logic signed [COEF_BITS-1:0]   t_rd;

  // Register values out of range act as the nearest limit.
  assign nt_eff = (tiu_q == '0) ? 4'd1 : ((tiu_q > 4'(MAX_TEMPLATES)) ? 4'(MAX_TEMPLATES) : tiu_q);
  assign nc_eff = (ciu_q < 7'd2) ? 7'd2 : ((ciu_q > 7'(MAX_CHANNELS)) ? 7'(MAX_CHANNELS) : ciu_q);

  assign in_stall_o = (state_q != SEQ_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign start_vec  = accept && (func_i == FUNC_SAMPLE)
                      && (channel_index_i == CH_AW'(nc_eff - 7'd1));
  assign issue      = (state_q == SEQ_SUM || state_q == SEQ_ENERGY || state_q == SEQ_DOT)
                      && (c_q < nc_eff);
  assign load_out   = (state_q == SEQ_DONE) && (!out_valid_q || !out_stall_i);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiu_q <= 4'd4;
      ciu_q <= 7'd32;
      pol_q <= 1'b1;
      dm_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TEMPLATES: tiu_q <= cfg_data_i[3:0];
        REG_CHANNELS:  ciu_q <= cfg_data_i;
        REG_POLARITY:  pol_q <= cfg_data_i[0];
        REG_DEMEAN:    dm_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Control to the multiply-accumulate unit.
  always_comb begin
    mac_ctl            = '0;
    mac_ctl.valid      = v1_q;
    mac_ctl.last       = last1_q;
    mac_ctl.pass       = (state_q == SEQ_SUM) ? PASS_SUM :
                         ((state_q == SEQ_ENERGY) ? PASS_ENERGY : PASS_DOT);
    mac_ctl.clr_sum    = start_vec;
    mac_ctl.first_tmpl = (k_q == '0);
    mac_ctl.demean     = dm_q;
    mac_ctl.inv        = pol_q;
    mac_ctl.k          = k_q;
    mac_ctl.nc         = nc_eff;
    mac_ctl.clr_acc    = ((state_q == SEQ_SUM) && mac_done)
                         || ((state_q == SEQ_ECHECK) && (energy != '0))
                         || ((state_q == SEQ_DOT) && mac_done);
  end

  // Sequencer next state.
  always_comb begin
    state_d     = state_q;
    c_d         = issue ? (c_q + 1'b1) : c_q;
    k_d         = k_q;
    res_label_d = res_label_q;
    res_corr_d  = res_corr_q;
    corr_start  = 1'b0;
    unique case (state_q)
      SEQ_IDLE: begin
        if (start_vec) begin
          state_d = SEQ_SUM;
          c_d     = '0;
        end
      end
      SEQ_SUM: begin
        if (mac_done) begin
          state_d = SEQ_ENERGY;
          c_d     = '0;
        end
      end
      SEQ_ENERGY: begin
        if (mac_done) begin
          state_d = SEQ_ECHECK;
        end
      end
      SEQ_ECHECK: begin
        if (energy == '0) begin
          res_label_d = LABEL_NONE;
          res_corr_d  = '0;
          state_d     = SEQ_DONE;
        end else begin
          state_d = SEQ_DOT;
          c_d     = '0;
          k_d     = '0;
        end
      end
      SEQ_DOT: begin
        if (mac_done) begin
          c_d = '0;
          if (k_q == TM_AW'(nt_eff - 4'd1)) begin
            state_d = SEQ_BEST;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      SEQ_BEST: begin
        res_label_d = 4'(best_k);
        if (best_key > 0) begin
          corr_start = 1'b1;
          state_d    = SEQ_CORR;
        end else begin
          res_corr_d = '0;
          state_d    = SEQ_DONE;
        end
      end
      SEQ_CORR: begin
        if (corr_done) begin
          res_corr_d = corr_val;
          state_d    = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        if (load_out) begin
          state_d = SEQ_IDLE;
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  // Sequencer and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      c_q         <= '0;
      k_q         <= '0;
      v1_q        <= 1'b0;
      last1_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      c_q     <= c_d;
      k_q     <= k_d;
      v1_q    <= issue;
      last1_q <= issue && (c_q == nc_eff - 7'd1);
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    res_label_q <= res_label_d;
    res_corr_q  <= res_corr_d;
    if (load_out) begin
      label_q <= res_label_q;
      corr_q  <= res_corr_q;
    end
  end

  mstc_store u_store (
    .clk_i          (clk_i),
    .tmpl_we_i      (accept && (func_i == FUNC_TEMPLATE)),
    .tmpl_waddr_i   ({template_index_i, channel_index_i}),
    .tmpl_wdata_i   (template_value_i),
    .vec_we_i       (accept && (func_i == FUNC_SAMPLE)),
    .vec_waddr_i    (channel_index_i),
    .vec_wdata_i    (sample_i),
    .rd_en_i        (issue),
    .rd_vec_addr_i  (c_q[CH_AW-1:0]),
    .rd_tmpl_addr_i ({k_q, c_q[CH_AW-1:0]}),
    .x_o            (x_rd),
    .t_o            (t_rd)
  );

  mstc_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mac_ctl),
    .x_i        (x_rd),
    .t_i        (t_rd),
    .done_o     (mac_done),
    .energy_o   (energy),
    .best_key_o (best_key),
    .best_k_o   (best_k)
  );

  mstc_corr u_corr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (corr_start),
    .mag_i    (best_key[MAG_W-1:0]),
    .energy_i (energy),
    .done_o   (corr_done),
    .corr_o   (corr_val)
  );

  assign out_valid_o = out_valid_q;
  assign label_o     = label_q;
  assign corr_o      = corr_q;

endmodule

// ===== hdl/mstc_store.sv =====
// Template store and vector buffer memories with registered read ports.
module mstc_store import mstc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          tmpl_we_i,
  input  logic [TS_AW-1:0]              tmpl_waddr_i,
  input  logic signed [COEF_BITS-1:0]   tmpl_wdata_i,
  input  logic                          vec_we_i,
  input  logic [CH_AW-1:0]              vec_waddr_i,
  input  logic signed [SAMPLE_BITS-1:0] vec_wdata_i,
  input  logic                          rd_en_i,
  input  logic [CH_AW-1:0]              rd_vec_addr_i,
  input  logic [TS_AW-1:0]              rd_tmpl_addr_i,
  output logic signed [SAMPLE_BITS-1:0] x_o,
  output logic signed [COEF_BITS-1:0]   t_o
);

  logic signed [COEF_BITS-1:0]   tmpl_mem [MAX_TEMPLATES*MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] vec_mem  [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [COEF_BITS-1:0]   t_q;

  // Template memory port.
  always_ff @(posedge clk_i) begin
    if (tmpl_we_i) begin
      tmpl_mem[tmpl_waddr_i] <= tmpl_wdata_i;
    end
    if (rd_en_i) begin
      t_q <= tmpl_mem[rd_tmpl_addr_i];
    end
  end

  // Vector buffer port.
  always_ff @(posedge clk_i) begin
    if (vec_we_i) begin
      vec_mem[vec_waddr_i] <= vec_wdata_i;
    end
    if (rd_en_i) begin
      x_q <= vec_mem[rd_vec_addr_i];
    end
  end

  assign x_o = x_q;
  assign t_o = t_q;

endmodule

// ===== hdl/mstc_mac.sv =====
// Shared multiply-accumulate unit: channel sum, energy and template dot products.
module mstc_mac import mstc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mac_ctl_t                      ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  input  logic signed [COEF_BITS-1:0]   t_i,
  output logic                          done_o,
  output logic [ENG_W-1:0]              energy_o,
  output logic signed [DOT_W-1:0]       best_key_o,
  output logic [TM_AW-1:0]              best_k_o
);

  logic signed [SUM_W-1:0]     sum_q;
  logic signed [Y_W-1:0]       y_q, y_d, ncx;
  logic signed [COEF_BITS-1:0] t_q;
  logic signed [Y_W-1:0]       mul_b;
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]     acc_q, acc_next;
  logic signed [DOT_W-1:0]     dot, key;
  logic signed [DOT_W-1:0]     best_key_q;
  logic [TM_AW-1:0]            best_k_q;
  logic [ENG_W-1:0]            energy_q;
  logic                        vb_q, lastb_q, vc_q, lastc_q;
  logic                        elem_go;

  // Stage A: form the (optionally demeaned) channel value.
  assign ncx     = $signed({1'b0, ctl_i.nc}) * $signed(x_i);
  assign y_d     = ctl_i.demean ? (ncx - Y_W'(sum_q)) : Y_W'(x_i);
  assign elem_go = ctl_i.valid && (ctl_i.pass != PASS_SUM);

  // Stage B operand: the value itself for energy, the template element for dots.
  assign mul_b = (ctl_i.pass == PASS_ENERGY) ? y_q : Y_W'(t_q);

  // Stage C accumulation and dot product ranking key.
  assign acc_next = acc_q + ACC_W'(prod_q);
  assign dot      = acc_next[DOT_W-1:0];
  assign key      = (ctl_i.inv && dot[DOT_W-1]) ? -dot : dot;

  // Pipeline control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q    <= 1'b0;
      lastb_q <= 1'b0;
      vc_q    <= 1'b0;
      lastc_q <= 1'b0;
    end else begin
      vb_q    <= elem_go;
      lastb_q <= elem_go && ctl_i.last;
      vc_q    <= vb_q;
      lastc_q <= lastb_q;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_sum) begin
      sum_q <= '0;
    end else if (ctl_i.valid && ctl_i.pass == PASS_SUM) begin
      sum_q <= sum_q + SUM_W'(x_i);
    end
    if (elem_go) begin
      y_q <= y_d;
      t_q <= t_i;
    end
    if (vb_q) begin
      prod_q <= y_q * mul_b;
    end
    if (ctl_i.clr_acc) begin
      acc_q <= '0;
    end else if (vc_q) begin
      acc_q <= acc_next;
    end
    if (vc_q && lastc_q && ctl_i.pass == PASS_ENERGY) begin
      energy_q <= acc_next[ENG_W-1:0];
    end
    if (vc_q && lastc_q && ctl_i.pass == PASS_DOT) begin
      if (ctl_i.first_tmpl || key > best_key_q) begin
        best_key_q <= key;
        best_k_q   <= ctl_i.k;
      end
    end
  end

  assign done_o = (ctl_i.pass == PASS_SUM) ? (ctl_i.valid && ctl_i.last) : (vc_q && lastc_q);
  assign energy_o   = energy_q;
  assign best_key_o = best_key_q;
  assign best_k_o   = best_k_q;

endmodule

// ===== hdl/mstc_corr.sv =====
// Iterative correlation unit: squares the best dot product, divides by energy, takes a root.
module mstc_corr import mstc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MAG_W-1:0]  mag_i,
  input  logic [ENG_W-1:0]  energy_i,
  output logic              done_o,
  output logic [CORR_W-1:0] corr_o
);

  corr_e               state_q, state_d;
  logic [5:0]          cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [MAG_W-1:0]    m_q, sh_q;
  logic [ENG_W-1:0]    e_q;
  logic [REM_W-1:0]    r_q, r_sq, d_q;
  logic [Q_W-1:0]      quot_q;
  logic                sat_q, ge;
  logic [CORR_W-1:0]   root_q, cand;
  logic [2*CORR_W-1:0] cand_sq;

  // One shift-add, one compare-subtract or one root trial per cycle.
  assign r_sq    = (r_q << 1) + (sh_q[MAG_W-1] ? REM_W'(m_q) : REM_W'(0));
  assign ge      = (r_q >= d_q);
  assign cand    = root_q | (CORR_W'(1) << cnt_q[3:0]);
  assign cand_sq = cand * cand;

  // Step sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      CORR_IDLE: begin
        if (start_i) begin
          state_d = CORR_SQUARE;
          cnt_d   = 6'(MAG_W - 1);
        end
      end
      CORR_SQUARE: begin
        if (cnt_q == '0) begin
          state_d = CORR_DIVIDE;
          cnt_d   = 6'(Q_W);
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      CORR_DIVIDE: begin
        if (cnt_q == '0) begin
          state_d = CORR_ROOT;
          cnt_d   = 6'(CORR_W - 1);
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      CORR_ROOT: begin
        if (sat_q || cnt_q == '0) begin
          state_d = CORR_IDLE;
          done_d  = 1'b1;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      default: state_d = CORR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CORR_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      CORR_IDLE: begin
        if (start_i) begin
          m_q  <= mag_i;
          sh_q <= mag_i;
          e_q  <= energy_i;
          r_q  <= '0;
        end
      end
      CORR_SQUARE: begin
        sh_q <= sh_q << 1;
        if (cnt_q == '0) begin
          // Dividend is four times the squared dot product.
          r_q    <= r_sq << 2;
          d_q    <= REM_W'(e_q) << Q_W;
          sat_q  <= 1'b0;
          quot_q <= '0;
        end else begin
          r_q <= r_sq;
        end
      end
      CORR_DIVIDE: begin
        if (ge) begin
          r_q <= r_q - d_q;
        end
        d_q <= d_q >> 1;
        // The first quotient bit only flags a quotient past the root's range.
        if (cnt_q == 6'(Q_W)) begin
          sat_q <= ge;
        end else begin
          quot_q <= {quot_q[Q_W-2:0], ge};
        end
        if (cnt_q == '0) begin
          root_q <= '0;
        end
      end
      CORR_ROOT: begin
        if (sat_q) begin
          root_q <= '1;
        end else if (cand_sq <= quot_q) begin
          root_q <= cand;
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign corr_o = root_q;

endmodule

// ===== hdl/mstc_checker.sv =====
// Port-level checker for the microstate template classifier and its bind statement.
module mstc_checker import mstc_pkg::*; (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          func_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [3:0]             label_o,
  input logic [CORR_W-1:0]             corr_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(label_o) && $stable(corr_o))
    else $error("result changed while stalled");

  // A zero-energy vector reports no correlation.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && label_o == LABEL_NONE |-> corr_o == '0)
    else $error("zero-energy label with nonzero corr");

  // Labels are a template index or the zero-energy code.
  a_label_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !label_o[3] || label_o == LABEL_NONE)
    else $error("label out of range");

  // The block only goes busy after accepting a sample transaction.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && func_i == FUNC_SAMPLE))
    else $error("input stalled without a completing sample");

  // A new result only appears at the end of a busy period.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a classified vector");

endmodule

bind microstate_template_classifier_unit mstc_checker u_mstc_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for the microstate template classifier unit.
`timescale 1ns / 1ps

module testbench;
  import mstc_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int DRAIN_CYCLES = 1000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int ITEMS_PER_PHASE = 20;

  // One expected classification.
  typedef struct {
    logic signed [3:0] label;
    logic [15:0]       corr;
  } verdict_t;

  // Scoreboard: mirrors the classifier state and holds the pending verdicts.
  class verdict_board;
    logic signed [15:0] tmpl [MAX_TEMPLATES][MAX_CHANNELS];
    logic signed [23:0] vec [MAX_CHANNELS];
    int unsigned n_tmpl = 4;
    int unsigned n_chan = 32;
    bit          pol_inv = 1'b1;
    bit          demean = 1'b1;
    verdict_t    pending_q[$];
    int          errors = 0;

    function void set_reg(logic [1:0] idx, logic [6:0] val);
      case (idx)
        REG_TEMPLATES: n_tmpl = val[3:0];
        REG_CHANNELS:  n_chan = val;
        REG_POLARITY:  pol_inv = val[0];
        REG_DEMEAN:    demean = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_tmpl();
      return (n_tmpl < 1) ? 1 : (n_tmpl > MAX_TEMPLATES) ? MAX_TEMPLATES : n_tmpl;
    endfunction

    function int unsigned eff_chan();
      return (n_chan < 2) ? 2 : (n_chan > MAX_CHANNELS) ? MAX_CHANNELS : n_chan;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Update the state for one accepted input and predict any verdict it completes.
    function void note_input(logic f, logic [2:0] tix, logic [5:0] cix,
                             logic signed [15:0] tv, logic signed [23:0] smp);
      int unsigned nt, nc;
      longint sum, dot, score, best;
      longint y [MAX_CHANNELS];
      bit [67:0] energy;
      bit [191:0] rhs, lhs_base, bm, cand;
      bit [15:0] q;
      int best_k;
      verdict_t v;
      if (f == FUNC_TEMPLATE) begin
        tmpl[tix][cix] = tv;
        return;
      end
      vec[cix] = smp;
      nt = eff_tmpl();
      nc = eff_chan();
      if (cix != nc - 1) return;
      sum = 0;
      for (int c = 0; c < nc; c++) sum += longint'(vec[c]);
      energy = '0;
      for (int c = 0; c < nc; c++) begin
        y[c] = demean ? longint'(nc) * longint'(vec[c]) - sum : longint'(vec[c]);
        energy += 68'(unsigned'(y[c] * y[c]));
      end
      if (energy == 0) begin
        v.label = LABEL_NONE;
        v.corr = '0;
        pending_q = {pending_q, v};
        return;
      end
      // First maximum of the (optionally absolute) dot products.
      best = 0;
      best_k = 0;
      for (int j = 0; j < nt; j++) begin
        dot = 0;
        for (int c = 0; c < nc; c++) dot += y[c] * longint'(tmpl[j][c]);
        score = (pol_inv && dot < 0) ? -dot : dot;
        if (j == 0 || score > best) begin
          best = score;
          best_k = j;
        end
      end
      // Bitwise search for the floored square root of dot^2 / (E * 2^30) in Q0.16.
      q = '0;
      if (best > 0) begin
        bm = 192'(best);
        rhs = (bm * bm) << 32;
        lhs_base = 192'(energy) << 30;
        for (int b = 15; b >= 0; b--) begin
          cand = 192'(q | (16'd1 << b));
          if (lhs_base * cand * cand <= rhs) q = cand[15:0];
        end
      end
      v.label = 4'(best_k);
      v.corr = q;
      pending_q = {pending_q, v};
    endfunction

    // Compare one accepted result transaction with the oldest expectation.
    function void check_result(logic signed [3:0] label, logic [15:0] corr);
      verdict_t v;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: label %0d corr %0d", label, corr);
        return;
      end
      v = pending_q.pop_front();
      if (label !== v.label || corr !== v.corr) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected label %0d corr %0d, got label %0d corr %0d",
                   v.label, v.corr, label, corr);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_TEMPLATES;
  logic [6:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = FUNC_TEMPLATE;
  logic [2:0] template_index = '0;
  logic [5:0] channel_index = '0;
  logic signed [15:0] template_value = '0;
  logic signed [23:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [3:0] label;
  logic [15:0] corr;

  verdict_board board = new();
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  microstate_template_classifier_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .func_i           (func),
    .template_index_i (template_index),
    .channel_index_i  (channel_index),
    .template_value_i (template_value),
    .sample_i         (sample),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .label_o          (label),
    .corr_o           (corr)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Run limit.
  initial begin
    #20000000;
    $display("microstate_template_classifier_unit: mismatch");
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request, result checks.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) board.check_result(label, corr);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (!calm && $urandom_range(99) < 12);
    end
  end

  // Offer one input transaction, with random idle cycles ahead of it.
  task automatic send(logic f, logic [2:0] tix, logic [5:0] cix,
                      logic signed [15:0] tv, logic signed [23:0] smp);
    if (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    func <= f;
    template_index <= tix;
    channel_index <= cix;
    template_value <= tv;
    sample <= smp;
    do @(posedge clk_i); while (in_stall);
    board.note_input(f, tix, cix, tv, smp);
  endtask

  // Wait until every expected result has arrived and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [6:0] nt, logic [6:0] nc, logic pi, logic dm);
    logic [6:0] vals [4];
    vals = '{nt, nc, 7'(pi), 7'(dm)};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk_i);
      board.set_reg(2'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [23:0] pick_sample(int style, int c);
    case (style)
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return c[0] ? 24'sh7FFFFF : 24'sh800000;
      3: return 24'sd12345;
      4: return 24'sd0;
      5: return 24'($signed($urandom_range(0, 2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_coef();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // A whole scalp vector in ascending channel order.
  task automatic send_vector(int style);
    int nc;
    nc = board.eff_chan();
    for (int c = 0; c < nc; c++) send(FUNC_SAMPLE, 3'd0, 6'(c), 16'($urandom), pick_sample(style, c));
  endtask

  initial begin
    logic [6:0] phase_cfg [8][4];
    int count, r;
    phase_cfg = '{'{7'd4, 7'd32, 7'd1, 7'd1}, '{7'd1, 7'd2, 7'd0, 7'd0},
                  '{7'd8, 7'd64, 7'd1, 7'd0}, '{7'd8, 7'd64, 7'd0, 7'd1},
                  '{7'd0, 7'd1, 7'd0, 7'd1}, '{7'd15, 7'd127, 7'd1, 7'd1},
                  '{7'd3, 7'd5, 7'd0, 7'd0}, '{7'd6, 7'd17, 7'd1, 7'd0}};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load every template element and every channel so no undefined entry is read.
    for (int k = 0; k < MAX_TEMPLATES; k++)
      for (int c = 0; c < MAX_CHANNELS; c++)
        send(FUNC_TEMPLATE, 3'(k), 6'(c), pick_coef(), 24'($urandom));
    for (int c = 0; c < MAX_CHANNELS; c++)
      send(FUNC_SAMPLE, 3'($urandom), 6'(c), 16'($urandom), 24'($urandom));
    drain();

    // Directed vectors at the reset settings: extremes, constant and zero vectors.
    for (int s = 0; s < 5; s++) send_vector(s);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_regs(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2][0], phase_cfg[p][3][0]);
      calm = (p == 1);
      // Short vectors here, so a completed vector waits for the output register while the receiver holds off.
      if (p == 6) hold_req = 1'b1;
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 75) begin
          send_vector($urandom_range(10));
          count += board.eff_chan();
        end else if (r < 87) begin
          send(FUNC_TEMPLATE, 3'($urandom), 6'($urandom), pick_coef(), 24'($urandom));
          count++;
        end else begin
          send(FUNC_SAMPLE, 3'($urandom), 6'($urandom), 16'($urandom), 24'($urandom));
          count++;
        end
      end
      drain();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("microstate_template_classifier_unit: match");
    end else begin
      $display("microstate_template_classifier_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mstc_pkg.sv
hdl/mstc_store.sv
hdl/mstc_mac.sv
hdl/mstc_corr.sv
hdl/microstate_template_classifier_unit.sv
hdl/mstc_checker.sv
verif/testbench.sv
